FILE: rtl/core/porp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// porp_pkg: shared types and constants
// Phase codes, field tags, register map and the result word of the
// proof-of-ownership request parser.
// ----------------------------------------------------------------------------
package porp_pkg;

    // Register map (word index on the config port)
    localparam logic [1:0] REG_SERVICE_ID   = 2'd0;
    localparam logic [1:0] REG_SUBFUNCTION  = 2'd1;
    localparam logic [1:0] REG_MAX_KEY_LEN  = 2'd2;

    localparam logic [7:0] RST_SERVICE_ID   = 8'd41;
    localparam logic [7:0] RST_SUBFUNCTION  = 8'd3;
    localparam logic [7:0] RST_MAX_KEY_LEN  = 8'd65;

    // Byte counter saturates here; reaching COUNT_SAT-1 marks an overlong message
    localparam logic [16:0] COUNT_SAT       = 17'd65536;

    // Field tags on the result word
    localparam logic [3:0] TAG_SID          = 4'd0;
    localparam logic [3:0] TAG_SUBFN        = 4'd1;
    localparam logic [3:0] TAG_ALG          = 4'd2;
    localparam logic [3:0] TAG_PROOF_LEN    = 4'd3;
    localparam logic [3:0] TAG_PROOF        = 4'd4;
    localparam logic [3:0] TAG_ECHO_LEN     = 4'd5;
    localparam logic [3:0] TAG_ECHO         = 4'd6;
    localparam logic [3:0] TAG_KEY_LEN      = 4'd7;
    localparam logic [3:0] TAG_KEY          = 4'd8;

    // Parser phase
    typedef enum logic [3:0] {
        PH_SID     = 4'd0,
        PH_SUBFN   = 4'd1,
        PH_ALG     = 4'd2,
        PH_PLEN_HI = 4'd3,
        PH_PLEN_LO = 4'd4,
        PH_PROOF   = 4'd5,
        PH_ECHOLEN = 4'd6,
        PH_ECHO    = 4'd7,
        PH_KEYLEN  = 4'd8,
        PH_KEY     = 4'd9,
        PH_TRAIL   = 4'd10
    } phase_t;

    // Configuration seen by the parser
    typedef struct packed {
        logic [7:0] service_id;
        logic [7:0] subfunction_id;
        logic [7:0] max_key_length;
    } cfg_t;

    // One result word
    typedef struct packed {
        logic [7:0]  byte_out;
        logic [3:0]  field_tag;
        logic        key_byte;
        logic        message_done;
        logic        status;
        logic [7:0]  alg_id;
        logic [15:0] proof_length;
        logic [7:0]  echo_length;
        logic [7:0]  key_length;
    } result_t;

endpackage

FILE: rtl/core/porp_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// porp_cfg_regs: configuration register file
// APB-style slave holding service id, subfunction id and key length limit.
// ----------------------------------------------------------------------------
module porp_cfg_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output porp_pkg::cfg_t    cfg
);
    import porp_pkg::*;

    logic [7:0] service_id_reg;
    logic [7:0] subfunction_reg;
    logic [7:0] max_key_len_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            service_id_reg  <= RST_SERVICE_ID;
            subfunction_reg <= RST_SUBFUNCTION;
            max_key_len_reg <= RST_MAX_KEY_LEN;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SERVICE_ID:  service_id_reg  <= pwdata[7:0];
                REG_SUBFUNCTION: subfunction_reg <= pwdata[7:0];
                REG_MAX_KEY_LEN: max_key_len_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_SERVICE_ID:  prdata = {24'd0, service_id_reg};
            REG_SUBFUNCTION: prdata = {24'd0, subfunction_reg};
            REG_MAX_KEY_LEN: prdata = {24'd0, max_key_len_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign cfg.service_id     = service_id_reg;
    assign cfg.subfunction_id = subfunction_reg;
    assign cfg.max_key_length = max_key_len_reg;

endmodule

FILE: rtl/core/porp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// porp_parser: request phase machine
// Holds the message state and forms the result word for the byte being
// accepted; state advances on each accepted byte and clears after the last.
// ----------------------------------------------------------------------------
module porp_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  porp_pkg::cfg_t      cfg,
    input  logic                in_acc,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output porp_pkg::result_t   result
);
    import porp_pkg::*;

    phase_t      phase_reg,     phase_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [16:0] count_reg,     count_next;
    logic        error_reg,     error_next;
    logic [7:0]  len_hi_reg,    len_hi_next;
    logic [7:0]  alg_reg,       alg_next;
    logic [15:0] plen_reg,      plen_next;
    logic [7:0]  echo_len_reg,  echo_len_next;
    logic [7:0]  key_len_reg,   key_len_next;
    logic [3:0]  tag;
    logic        key_flag;
    logic [15:0] rem_dec;

    assign rem_dec = remaining_reg - 16'd1;

    // Next state and result for the byte at the input
    always_comb begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        error_next     = error_reg;
        len_hi_next    = len_hi_reg;
        alg_next       = alg_reg;
        plen_next      = plen_reg;
        echo_len_next  = echo_len_reg;
        key_len_next   = key_len_reg;
        tag            = TAG_KEY;
        key_flag       = 1'b0;

        // overlong message: saturate and flag
        if (count_reg >= COUNT_SAT - 17'd1) begin
            error_next = 1'b1;
            count_next = COUNT_SAT;
        end else begin
            count_next = count_reg + 17'd1;
        end

        case (phase_reg)
            PH_SID: begin
                tag = TAG_SID;
                if (data_byte != cfg.service_id) error_next = 1'b1;
                phase_next = PH_SUBFN;
            end
            PH_SUBFN: begin
                tag = TAG_SUBFN;
                if (data_byte != cfg.subfunction_id) error_next = 1'b1;
                phase_next = PH_ALG;
            end
            PH_ALG: begin
                tag        = TAG_ALG;
                alg_next   = data_byte;
                phase_next = PH_PLEN_HI;
            end
            PH_PLEN_HI: begin
                tag         = TAG_PROOF_LEN;
                len_hi_next = data_byte;
                phase_next  = PH_PLEN_LO;
            end
            PH_PLEN_LO: begin
                tag            = TAG_PROOF_LEN;
                plen_next      = {len_hi_reg, data_byte};
                remaining_next = {len_hi_reg, data_byte};
                if ({len_hi_reg, data_byte} == 16'd0) begin
                    error_next = 1'b1;
                    phase_next = PH_ECHOLEN;
                end else begin
                    phase_next = PH_PROOF;
                end
            end
            PH_PROOF: begin
                tag            = TAG_PROOF;
                remaining_next = rem_dec;
                if (rem_dec == 16'd0) phase_next = PH_ECHOLEN;
            end
            PH_ECHOLEN: begin
                tag            = TAG_ECHO_LEN;
                echo_len_next  = data_byte;
                remaining_next = {8'd0, data_byte};
                phase_next     = (data_byte == 8'd0) ? PH_KEYLEN : PH_ECHO;
            end
            PH_ECHO: begin
                tag            = TAG_ECHO;
                remaining_next = rem_dec;
                if (rem_dec == 16'd0) phase_next = PH_KEYLEN;
            end
            PH_KEYLEN: begin
                tag            = TAG_KEY_LEN;
                key_len_next   = data_byte;
                remaining_next = {8'd0, data_byte};
                if (data_byte == 8'd0) begin
                    error_next = 1'b1;
                    phase_next = PH_TRAIL;
                end else begin
                    if (data_byte > cfg.max_key_length) error_next = 1'b1;
                    phase_next = PH_KEY;
                end
            end
            PH_KEY: begin
                tag            = TAG_KEY;
                key_flag       = 1'b1;
                remaining_next = rem_dec;
                if (rem_dec == 16'd0) phase_next = PH_TRAIL;
            end
            default: begin
                // trailing bytes after the key
                tag        = TAG_KEY;
                phase_next = PH_TRAIL;
            end
        endcase

        result.byte_out      = data_byte;
        result.field_tag     = tag;
        result.key_byte      = key_flag;
        result.message_done  = last_byte;
        result.status        = last_byte && (error_next || (phase_next != PH_TRAIL));
        result.alg_id        = alg_next;
        result.proof_length  = plen_next;
        result.echo_length   = echo_len_next;
        result.key_length    = key_len_next;
    end

    // Message state; last byte returns everything to the start
    always_ff @(posedge aclk) begin
        if (!aresetn || (in_acc && last_byte)) begin
            phase_reg     <= PH_SID;
            remaining_reg <= 16'd0;
            count_reg     <= 17'd0;
            error_reg     <= 1'b0;
            len_hi_reg    <= 8'd0;
            alg_reg       <= 8'd0;
            plen_reg      <= 16'd0;
            echo_len_reg  <= 8'd0;
            key_len_reg   <= 8'd0;
        end else if (in_acc) begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            count_reg     <= count_next;
            error_reg     <= error_next;
            len_hi_reg    <= len_hi_next;
            alg_reg       <= alg_next;
            plen_reg      <= plen_next;
            echo_len_reg  <= echo_len_next;
            key_len_reg   <= key_len_next;
        end
    end

    // Counter never passes saturation
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_SAT)
        else $error("byte counter beyond saturation");

    // Accepted last byte always brings the machine back to the start
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && last_byte |=> phase_reg == PH_SID && !error_reg && count_reg == 17'd0)
        else $error("state not cleared after last byte");

    // Key data only tagged as key
    assert property (@(posedge aclk) disable iff (!aresetn)
        result.key_byte |-> result.field_tag == TAG_KEY)
        else $error("key byte with wrong tag");

endmodule

FILE: rtl/core/porp_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// porp_out_stage: result register with skid entry
// Holds the result word for the master side; a second entry catches a word
// accepted while the output is stalled, so input ready is a register.
// ----------------------------------------------------------------------------
module porp_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_acc,
    input  porp_pkg::result_t   in_word,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output porp_pkg::result_t   out_word
);
    import porp_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_word_reg;
    result_t skid_word_reg;
    logic    out_pop;

    assign out_pop   = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_pop || !out_valid_reg) begin
            out_valid_reg  <= skid_valid_reg || in_acc;
            skid_valid_reg <= 1'b0;
        end else if (in_acc) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (out_pop || !out_valid_reg) begin
            out_word_reg <= skid_valid_reg ? skid_word_reg : in_word;
        end else if (in_acc) begin
            skid_word_reg <= in_word;
        end
    end

    // Skid entry only holds a word behind a full output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full with empty output");

    // A word taken during a stall lands in the skid entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && out_valid_reg && !out_ready |=> skid_valid_reg)
        else $error("word lost during output stall");

    // A pop with the skid full drains the skid
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_pop && skid_valid_reg |=> !skid_valid_reg && out_valid_reg)
        else $error("skid entry not drained");

endmodule

FILE: rtl/core/proof_of_ownership_request_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proof_of_ownership_request_parser_core: authentication request parser
//
//   channel   direction  word                                   end marker
//   s_axis    in         tdata[7:0] message byte                tlast = last byte
//   m_axis    out        tdata: byte, status, captured lengths  tlast = message done
//                        tuser: field tag, key-byte flag
//   apb       in/out     service id, subfunction, max key len   -
//
// One byte per cycle while s_tready is high: each accepted byte is parsed in the cycle
// it is taken and its result word is registered for the master side.
// The phase machine plus a one-word skid entry sets this rate; s_tready is
// registered and drops only when both output entries are full.
// Reset (aresetn low, synchronous) empties the output and restores registers;
// message state also clears after every last byte.
// ----------------------------------------------------------------------------
module proof_of_ownership_request_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [7:0] byte_out, [8] status, [16:9] alg_id,
                                   // [32:17] proof_length, [40:33] echo_length,
                                   // [48:41] key_length, [55:49] zero
    output logic [4:0]  m_tuser,   // [3:0] field_tag, [4] key_byte
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import porp_pkg::*;

    cfg_t    cfg;
    result_t parse_word;
    result_t out_word;
    logic    in_acc;

    assign in_acc = s_tvalid && s_tready;

    porp_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    porp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_acc    (in_acc),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .result    (parse_word)
    );

    porp_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_acc    (in_acc),
        .in_word   (parse_word),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    // Pack the result word onto the stream
    assign m_tdata = {7'd0,
                      out_word.key_length,
                      out_word.echo_length,
                      out_word.proof_length,
                      out_word.alg_id,
                      out_word.status,
                      out_word.byte_out};
    assign m_tuser = {out_word.key_byte, out_word.field_tag};
    assign m_tlast = out_word.message_done;

endmodule

FILE: tb/proof_of_ownership_request_parser_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proof_of_ownership_request_parser_core_test: self-checking bench
// Streams request bytes into the parser and keeps its own copy of the phase
// machine to compute the word due back for every accepted byte. A short
// directed table runs first, then random well-formed, truncated and noise
// requests under several register settings, with random idling on both sides
// and one long back-pressure hold.
// ----------------------------------------------------------------------------
module proof_of_ownership_request_parser_core_test;
    import porp_pkg::*;

    localparam int QUIET_LIMIT = 2000;   // cycles with no handshake and no APB select
    localparam int HOLD_CYCLES = 300;    // receiver hold-off for back-pressure
    localparam int PHASE_ITEMS = 300;

    // One stimulus word: the byte, its end flag and, for rows whose result
    // is plain to see, the typed-in result word.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       known;
        result_t    exp;
    } stim_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] data_byte
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;    // [7:0] byte, [8] status, [16:9] alg, [32:17] proof len,
                             // [40:33] echo len, [48:41] key len
    logic [4:0]  m_tuser;    // [3:0] field tag, [4] key byte
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    proof_of_ownership_request_parser_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Parser copy: registers and per-request state
    cfg_t        cfg = '{service_id: RST_SERVICE_ID, subfunction_id: RST_SUBFUNCTION,
                         max_key_length: RST_MAX_KEY_LEN};
    phase_t      ph;
    logic [15:0] left;
    logic [16:0] byte_cnt;
    logic        bad;
    logic [7:0]  len_hi;
    logic [7:0]  alg_q;
    logic [15:0] plen_q;
    logic [7:0]  elen_q;
    logic [7:0]  klen_q;

    result_t     pending_words[$];   // result words owed by the block, oldest first
    logic [7:0]  msg[$];             // request being sent
    stim_t       cur_word;           // word now offered on the input
    stim_t       directed_rows [0:21];
    int          error_count = 0;
    int          gap_pct = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    task automatic flag_error(input string text);
        error_count++;
        if (error_count <= 10) $display("ERROR at %0t: %s", $time, text);
    endtask

    function automatic string fmt_word(input result_t w);
        return $sformatf("byte=%02h tag=%0d key=%0b done=%0b st=%0b alg=%02h plen=%04h elen=%02h klen=%02h",
                         w.byte_out, w.field_tag, w.key_byte, w.message_done, w.status,
                         w.alg_id, w.proof_length, w.echo_length, w.key_length);
    endfunction

    function automatic result_t known_word(input logic [7:0] b, input logic [3:0] tag,
                                           input logic kb, input logic done,
                                           input logic st, input logic [7:0] alg,
                                           input logic [15:0] plen, input logic [7:0] elen,
                                           input logic [7:0] klen);
        result_t w;
        w.byte_out = b;
        w.field_tag = tag;
        w.key_byte = kb;
        w.message_done = done;
        w.status = st;
        w.alg_id = alg;
        w.proof_length = plen;
        w.echo_length = elen;
        w.key_length = klen;
        return w;
    endfunction

    function automatic stim_t row_pred(input logic [7:0] b, input logic last);
        stim_t s;
        s.data = b;
        s.last = last;
        s.known = 1'b0;
        s.exp = '0;
        return s;
    endfunction

    function automatic stim_t row_known(input logic [7:0] b, input logic last,
                                        input result_t w);
        stim_t s;
        s.data = b;
        s.last = last;
        s.known = 1'b1;
        s.exp = w;
        return s;
    endfunction

    function automatic void clear_request_state();
        ph = PH_SID;
        left = '0;
        byte_cnt = '0;
        bad = 1'b0;
        len_hi = '0;
        alg_q = '0;
        plen_q = '0;
        elen_q = '0;
        klen_q = '0;
    endfunction

    // Advance the parser copy by one byte and return the word it produces
    function automatic result_t parse_byte(input logic [7:0] b, input logic last);
        result_t     w;
        logic [3:0]  tag;
        logic        kb;
        tag = TAG_KEY;
        kb = 1'b0;
        // overlong request: counter saturates and the error sticks
        if (byte_cnt >= COUNT_SAT - 17'd1) begin
            bad = 1'b1;
            byte_cnt = COUNT_SAT;
        end else begin
            byte_cnt = byte_cnt + 17'd1;
        end
        case (ph)
            PH_SID: begin
                tag = TAG_SID;
                if (b != cfg.service_id) bad = 1'b1;
                ph = PH_SUBFN;
            end
            PH_SUBFN: begin
                tag = TAG_SUBFN;
                if (b != cfg.subfunction_id) bad = 1'b1;
                ph = PH_ALG;
            end
            PH_ALG: begin
                tag = TAG_ALG;
                alg_q = b;
                ph = PH_PLEN_HI;
            end
            PH_PLEN_HI: begin
                tag = TAG_PROOF_LEN;
                len_hi = b;
                ph = PH_PLEN_LO;
            end
            PH_PLEN_LO: begin
                tag = TAG_PROOF_LEN;
                plen_q = {len_hi, b};
                left = {len_hi, b};
                if ({len_hi, b} == 16'd0) begin
                    bad = 1'b1;
                    ph = PH_ECHOLEN;
                end else begin
                    ph = PH_PROOF;
                end
            end
            PH_PROOF: begin
                tag = TAG_PROOF;
                left = left - 16'd1;
                if (left == 16'd0) ph = PH_ECHOLEN;
            end
            PH_ECHOLEN: begin
                tag = TAG_ECHO_LEN;
                elen_q = b;
                left = {8'd0, b};
                ph = (b == 8'd0) ? PH_KEYLEN : PH_ECHO;
            end
            PH_ECHO: begin
                tag = TAG_ECHO;
                left = left - 16'd1;
                if (left == 16'd0) ph = PH_KEYLEN;
            end
            PH_KEYLEN: begin
                tag = TAG_KEY_LEN;
                klen_q = b;
                left = {8'd0, b};
                if (b == 8'd0) begin
                    bad = 1'b1;
                    ph = PH_TRAIL;
                end else begin
                    if (b > cfg.max_key_length) bad = 1'b1;
                    ph = PH_KEY;
                end
            end
            PH_KEY: begin
                tag = TAG_KEY;
                kb = 1'b1;
                left = left - 16'd1;
                if (left == 16'd0) ph = PH_TRAIL;
            end
            default: begin
                tag = TAG_KEY;
                ph = PH_TRAIL;
            end
        endcase
        w = known_word(b, tag, kb, last, last && (bad || ph != PH_TRAIL),
                       alg_q, plen_q, elen_q, klen_q);
        if (last) clear_request_state();
        return w;
    endfunction

    // Mostly short gaps, some medium, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Check outgoing words, then log incoming bytes
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.byte_out = m_tdata[7:0];
            got.status = m_tdata[8];
            got.alg_id = m_tdata[16:9];
            got.proof_length = m_tdata[32:17];
            got.echo_length = m_tdata[40:33];
            got.key_length = m_tdata[48:41];
            got.field_tag = m_tuser[3:0];
            got.key_byte = m_tuser[4];
            got.message_done = m_tlast;
            if (pending_words.size() == 0) begin
                flag_error($sformatf("unexpected word %s", fmt_word(got)));
            end else begin
                want = pending_words.pop_front();
                if (got !== want)
                    flag_error($sformatf("word mismatch\n  exp %s\n  got %s",
                                         fmt_word(want), fmt_word(got)));
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            want = parse_byte(cur_word.data, cur_word.last);
            pending_words.push_back(cur_word.known ? cur_word.exp : want);
        end
    end

    // Watchdog on handshake activity
    always @(posedge aclk) begin
        if (!aresetn || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("proof_of_ownership_request_parser_core_test: errors");
            $finish;
        end
    end

    // Result sink: random stalls, plus the long hold when requested
    initial begin : result_sink
        int stall;
        stall = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(99) < gap_pct) stall = pick_gap();
            end
        end
    end

    // Offer one word and wait for it to be taken; starts and ends at a falling edge
    task automatic push_word(input stim_t w);
        int n;
        if ($urandom_range(99) < gap_pct) begin
            n = pick_gap();
            s_tvalid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
        cur_word = w;
        s_tvalid <= 1'b1;
        s_tdata <= w.data;
        s_tlast <= w.last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_request();
        for (int i = 0; i < msg.size(); i++)
            push_word(row_pred(msg[i], i == msg.size() - 1));
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_SERVICE_ID:  cfg.service_id = value;
            REG_SUBFUNCTION: cfg.subfunction_id = value;
            REG_MAX_KEY_LEN: cfg.max_key_length = value;
            default: ;
        endcase
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic apb_check(input logic [1:0] idx, input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== {24'd0, value})
            flag_error($sformatf("register %0d read %08h, exp %02h", idx, prdata, value));
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic apply_settings(input logic [7:0] sid, input logic [7:0] sub,
                                  input logic [7:0] maxk);
        apb_write(REG_SERVICE_ID, sid);
        apb_write(REG_SUBFUNCTION, sub);
        apb_write(REG_MAX_KEY_LEN, maxk);
        apb_check(REG_SERVICE_ID, sid);
        apb_check(REG_SUBFUNCTION, sub);
        apb_check(REG_MAX_KEY_LEN, maxk);
    endtask

    // Wait until every owed word is back, then for the pipeline to settle
    task automatic drain();
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        @(negedge aclk);
        while (pending_words.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Build one random request: mostly well-formed, some cut short, some noise
    task automatic compose_request();
        int kind;
        int plen;
        int elen;
        int klen;
        int lim;
        int n;
        kind = $urandom_range(99);
        msg.delete();
        if (kind < 10) begin
            n = $urandom_range(1, 12);
            repeat (n) msg.push_back(8'($urandom));
        end else begin
            msg.push_back(($urandom_range(99) < 90) ? cfg.service_id : 8'($urandom));
            msg.push_back(($urandom_range(99) < 90) ? cfg.subfunction_id : 8'($urandom));
            msg.push_back(8'($urandom));
            n = $urandom_range(99);
            if (n < 5)       plen = 0;
            else if (n < 85) plen = $urandom_range(1, 6);
            else if (n < 95) plen = $urandom_range(7, 40);
            else             plen = $urandom_range(256, 300);
            msg.push_back(8'(plen >> 8));
            msg.push_back(8'(plen));
            repeat (plen) msg.push_back(8'($urandom));
            elen = ($urandom_range(99) < 30) ? 0 : $urandom_range(1, 5);
            msg.push_back(8'(elen));
            repeat (elen) msg.push_back(8'($urandom));
            // key length: zero, at the limit, just over it (any length at a limit of 255), or a small legal one
            lim = (int'(cfg.max_key_length) < 6) ? int'(cfg.max_key_length) : 6;
            n = $urandom_range(99);
            if (n < 5)       klen = 0;
            else if (n < 15) klen = int'(cfg.max_key_length);
            else if (n < 25) klen = (int'(cfg.max_key_length) < 255)
                                    ? int'(cfg.max_key_length) + 1
                                    : $urandom_range(1, 255);
            else             klen = $urandom_range(1, lim);
            msg.push_back(8'(klen));
            repeat (klen) msg.push_back(8'($urandom));
            if ($urandom_range(99) >= 75) begin
                n = $urandom_range(1, 2);
                repeat (n) msg.push_back(8'($urandom));
            end
            if (kind < 25 && msg.size() > 1) begin
                n = $urandom_range(1, msg.size() - 1);
                while (msg.size() > n) void'(msg.pop_back());
            end
        end
    endtask

    task automatic random_traffic(input int quota);
        int sent;
        sent = 0;
        while (sent < quota) begin
            compose_request();
            send_request();
            sent += msg.size();
        end
    endtask

    // Stimulus and end of run
    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cur_word = '0;
        clear_request_state();

        directed_rows = '{
            // clean request at reset settings
            row_known(8'd41, 1'b0, known_word(8'd41, TAG_SID, 1'b0, 1'b0, 1'b0, 8'h00,
                                              16'h0000, 8'h00, 8'h00)),
            row_pred(8'd3, 1'b0),
            row_pred(8'hFF, 1'b0),
            row_pred(8'h00, 1'b0),
            row_pred(8'h01, 1'b0),
            row_pred(8'h80, 1'b0),
            row_pred(8'h00, 1'b0),          // no echo
            row_pred(8'h01, 1'b0),
            row_known(8'h7F, 1'b1, known_word(8'h7F, TAG_KEY, 1'b1, 1'b1, 1'b0, 8'hFF,
                                              16'h0001, 8'h00, 8'h01)),
            // single wrong byte
            row_known(8'h00, 1'b1, known_word(8'h00, TAG_SID, 1'b0, 1'b1, 1'b1, 8'h00,
                                              16'h0000, 8'h00, 8'h00)),
            // wrong subfunction, zero proof length, echo, zero key length, trailer
            row_pred(8'd41, 1'b0),
            row_pred(8'hFE, 1'b0),
            row_pred(8'h00, 1'b0),
            row_pred(8'h00, 1'b0),
            row_known(8'h00, 1'b0, known_word(8'h00, TAG_PROOF_LEN, 1'b0, 1'b0, 1'b0,
                                              8'h00, 16'h0000, 8'h00, 8'h00)),
            row_pred(8'h02, 1'b0),
            row_pred(8'hFF, 1'b0),
            row_pred(8'h00, 1'b0),
            row_pred(8'h00, 1'b0),
            row_known(8'hC3, 1'b1, known_word(8'hC3, TAG_KEY, 1'b0, 1'b1, 1'b1, 8'h00,
                                              16'h0000, 8'h02, 8'h00)),
            // request cut short after the subfunction
            row_pred(8'd41, 1'b0),
            row_known(8'd3, 1'b1, known_word(8'd3, TAG_SUBFN, 1'b0, 1'b1, 1'b1, 8'h00,
                                             16'h0000, 8'h00, 8'h00))
        };

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset values, then the directed table
        apb_check(REG_SERVICE_ID, RST_SERVICE_ID);
        apb_check(REG_SUBFUNCTION, RST_SUBFUNCTION);
        apb_check(REG_MAX_KEY_LEN, RST_MAX_KEY_LEN);
        gap_pct = 30;
        foreach (directed_rows[i]) push_word(directed_rows[i]);
        drain();

        // smallest key limit, random ids
        apply_settings(8'($urandom), 8'($urandom), 8'd1);
        random_traffic(PHASE_ITEMS);
        drain();

        // zero ids, largest key limit, no idling; the sink holds off for a while
        apply_settings(8'd0, 8'd0, 8'd255);
        gap_pct = 0;
        hold_left = HOLD_CYCLES;
        random_traffic(PHASE_ITEMS);
        drain();

        // all-ones ids, heavy idling
        apply_settings(8'hFF, 8'hFF, 8'($urandom_range(2, 254)));
        gap_pct = 60;
        random_traffic(PHASE_ITEMS);
        drain();

        apply_settings(8'($urandom), 8'($urandom), 8'($urandom_range(1, 255)));
        gap_pct = 30;
        random_traffic(PHASE_ITEMS);
        drain();

        // back to reset settings
        apply_settings(RST_SERVICE_ID, RST_SUBFUNCTION, RST_MAX_KEY_LEN);
        gap_pct = 15;
        random_traffic(PHASE_ITEMS);
        drain();

        repeat (10) @(posedge aclk);
        if (error_count == 0 && pending_words.size() == 0) begin
            $display("proof_of_ownership_request_parser_core_test: clean");
        end else begin
            $display("proof_of_ownership_request_parser_core_test: errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/porp_pkg.sv
rtl/core/porp_cfg_regs.sv
rtl/core/porp_parser.sv
rtl/core/porp_out_stage.sv
rtl/core/proof_of_ownership_request_parser_core.sv
tb/proof_of_ownership_request_parser_core_test.sv
